/* design/ospab_pkg.sv */
// ospab_pkg: shared types and codes for the alarm bank
// item structs, operation and status codes, controller/datapath handshake structs
// no dependencies
package ospab_pkg;

	localparam logic [3:0] OP_CREATE      = 4'd0;
	localparam logic [3:0] OP_DELETE      = 4'd1;
	localparam logic [3:0] OP_ONCE        = 4'd2;
	localparam logic [3:0] OP_ONCE_AT     = 4'd3;
	localparam logic [3:0] OP_PERIODIC    = 4'd4;
	localparam logic [3:0] OP_PERIODIC_AT = 4'd5;
	localparam logic [3:0] OP_STOP        = 4'd6;
	localparam logic [3:0] OP_RESTART     = 4'd7;
	localparam logic [3:0] OP_QUERY       = 4'd8;
	localparam logic [3:0] OP_TIME        = 4'd9;
	localparam logic [3:0] OP_TICK        = 4'd10;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVAL   = 2'd1;
	localparam logic [1:0] ST_STATE   = 2'd2;
	localparam logic [1:0] ST_NO_FREE = 2'd3;

	typedef struct packed {
		logic [3:0]  operation;
		logic [3:0]  slot;
		logic [63:0] time_us;
		logic [63:0] first_at_us;
		logic [63:0] now_us;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  result_slot;
		logic        is_active;
		logic [63:0] time_now_us;
		logic        fired;
		logic        last;
	} out_item_t;

	// one slot's timing entry
	typedef struct packed {
		logic [63:0] alarm;
		logic [63:0] period;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // latch the input item and read its slot
		logic exec;   // carry out a single-result operation
		logic step;   // evaluate one slot of a tick scan
		logic close;  // send the closing result of a tick
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic due;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

/* design/ospab_ctrl.sv */
// ospab_ctrl: sequencing state machine of the alarm bank
// drives cmd_t to the datapath from its sts_t; uses ospab_pkg
module ospab_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  ospab_pkg::sts_t  sts,
	output ospab_pkg::cmd_t  cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_CLOSE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.is_tick) begin
					state_d = S_SCAN;
				end else if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SCAN: begin
				// a due slot waits for room in the output register
				if (!sts.due || sts.out_free) begin
					cmd.step = 1'b1;
					if (sts.scan_last) state_d = S_CLOSE;
				end
			end
			S_CLOSE: begin
				if (sts.out_free) begin
					cmd.close = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/ospab_dp.sv */
// ospab_dp: datapath of the alarm bank
// slot flags, alarm/period memory, scan index and output register; uses ospab_pkg
module ospab_dp #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ospab_pkg::cmd_t      cmd,
	output ospab_pkg::sts_t      sts,
	input  ospab_pkg::in_item_t  req,
	input  logic                 rsp_stall,
	output logic                 rsp_valid,
	output ospab_pkg::out_item_t rsp
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

	ospab_pkg::in_item_t  req_q;
	ospab_pkg::entry_t    mem_q [NUM_SLOTS];
	ospab_pkg::entry_t    rd_q;
	ospab_pkg::entry_t    wdata;
	ospab_pkg::out_item_t out_q;
	ospab_pkg::out_item_t out_d;
	logic                 out_valid_q;
	logic                 out_ld;

	logic [NUM_SLOTS-1:0] alloc_q;
	logic [NUM_SLOTS-1:0] alloc_d;
	logic [NUM_SLOTS-1:0] active_q;
	logic [NUM_SLOTS-1:0] active_d;
	logic [IW-1:0]        idx_q;
	logic [IW-1:0]        sidx;
	logic [IW-1:0]        raddr;
	logic [IW-1:0]        waddr;
	logic [IW-1:0]        free_idx;
	logic                 free_found;
	logic                 re;
	logic                 we;
	logic                 sok;
	logic                 v;
	logic                 act;
	logic                 due;
	logic [63:0]          sum;
	logic [1:0]           st;

	function automatic logic slot_in_range(input logic [3:0] s);
		return ({28'd0, s} < 32'(NUM_SLOTS));
	endfunction

	function automatic logic [IW-1:0] slot_to_idx(input logic [3:0] s);
		return slot_in_range(s) ? IW'(s) : '0;
	endfunction

	assign sok  = slot_in_range(req_q.slot);
	assign sidx = slot_to_idx(req_q.slot);
	assign v    = sok && alloc_q[sidx];
	assign act  = active_q[sidx];
	assign sum  = req_q.now_us + req_q.time_us;
	assign due  = alloc_q[idx_q] && active_q[idx_q] && (rd_q.alarm <= req_q.now_us);

	assign sts.is_tick   = (req_q.operation == ospab_pkg::OP_TICK);
	assign sts.due       = due;
	assign sts.scan_last = (idx_q == LAST_IDX);
	assign sts.out_free  = !out_valid_q || !rsp_stall;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!alloc_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	// read port: addressed slot on load (slot 0 for a tick), next slot during a scan
	always_comb begin
		re    = 1'b0;
		raddr = '0;
		if (cmd.load) begin
			re    = 1'b1;
			raddr = (req.operation == ospab_pkg::OP_TICK) ? '0 : slot_to_idx(req.slot);
		end else if (cmd.step && !sts.scan_last) begin
			re    = 1'b1;
			raddr = idx_q + 1'b1;
		end
	end

	always_comb begin
		alloc_d  = alloc_q;
		active_d = active_q;
		we       = 1'b0;
		waddr    = sidx;
		wdata    = '0;
		st       = ospab_pkg::ST_OK;
		out_ld   = 1'b0;
		out_d    = '0;
		if (cmd.exec) begin
			out_ld     = 1'b1;
			out_d.last = 1'b1;
			unique case (req_q.operation)
				ospab_pkg::OP_CREATE: begin
					if (free_found) begin
						alloc_d[free_idx]  = 1'b1;
						active_d[free_idx] = 1'b0;
						we                 = 1'b1;
						waddr              = free_idx;
						out_d.result_slot  = 4'(free_idx);
					end else begin
						st = ospab_pkg::ST_NO_FREE;
					end
				end
				ospab_pkg::OP_DELETE: begin
					if (!v) begin
						st = ospab_pkg::ST_INVAL;
					end else begin
						alloc_d[sidx]  = 1'b0;
						active_d[sidx] = 1'b0;
						we             = 1'b1;
					end
				end
				ospab_pkg::OP_ONCE, ospab_pkg::OP_PERIODIC: begin
					if (!v || sum == 64'd0) begin
						st = ospab_pkg::ST_INVAL;
					end else if (act) begin
						st = ospab_pkg::ST_STATE;
					end else begin
						we             = 1'b1;
						wdata.alarm    = sum;
						wdata.period   = (req_q.operation == ospab_pkg::OP_PERIODIC) ?
						                 req_q.time_us : 64'd0;
						active_d[sidx] = 1'b1;
					end
				end
				ospab_pkg::OP_ONCE_AT: begin
					if (!v || req_q.time_us <= req_q.now_us) begin
						st = ospab_pkg::ST_INVAL;
					end else if (act) begin
						st = ospab_pkg::ST_STATE;
					end else begin
						we             = 1'b1;
						wdata.alarm    = req_q.time_us;
						active_d[sidx] = 1'b1;
					end
				end
				ospab_pkg::OP_PERIODIC_AT: begin
					if (!v || req_q.first_at_us <= req_q.now_us) begin
						st = ospab_pkg::ST_INVAL;
					end else if (act) begin
						st = ospab_pkg::ST_STATE;
					end else begin
						we             = 1'b1;
						wdata.alarm    = req_q.first_at_us;
						wdata.period   = req_q.time_us;
						active_d[sidx] = 1'b1;
					end
				end
				ospab_pkg::OP_STOP: begin
					if (!v) st = ospab_pkg::ST_INVAL;
					else if (!act) st = ospab_pkg::ST_STATE;
					else active_d[sidx] = 1'b0;
				end
				ospab_pkg::OP_RESTART: begin
					if (!v) begin
						st = ospab_pkg::ST_INVAL;
					end else if (!act || req_q.time_us == 64'd0) begin
						st = ospab_pkg::ST_STATE;
					end else begin
						// a one-shot keeps its zero period
						we           = 1'b1;
						wdata.alarm  = sum;
						wdata.period = (rd_q.period != 64'd0) ? req_q.time_us : 64'd0;
					end
				end
				ospab_pkg::OP_QUERY: out_d.is_active = v && act;
				ospab_pkg::OP_TIME:  out_d.time_now_us = req_q.now_us;
				default:             st = ospab_pkg::ST_INVAL;
			endcase
			out_d.status = st;
		end else if (cmd.step && due) begin
			out_ld            = 1'b1;
			out_d.result_slot = 4'(idx_q);
			out_d.fired       = 1'b1;
			if (rd_q.period != 64'd0) begin
				we           = 1'b1;
				waddr        = idx_q;
				wdata.alarm  = rd_q.alarm + rd_q.period;
				wdata.period = rd_q.period;
			end else begin
				active_d[idx_q] = 1'b0;
			end
		end else if (cmd.close) begin
			out_ld     = 1'b1;
			out_d.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (we) mem_q[waddr] <= wdata;
		if (re) rd_q <= mem_q[raddr];
		if (out_ld) out_q <= out_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q     <= '0;
			active_q    <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			alloc_q  <= alloc_d;
			active_q <= active_d;
			if (cmd.load) idx_q <= '0;
			else if (cmd.step && !sts.scan_last) idx_q <= idx_q + 1'b1;
			if (out_ld) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_active_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q & ~alloc_q) == '0)
		else $error("active slot that is not allocated");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("scan index beyond the last slot");

	a_load_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !out_ld)
		else $error("item taken in the cycle a result is produced");

	a_fired_shape: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.step && due) |-> out_valid_q && out_q.fired && !out_q.last)
		else $error("due slot did not produce a fired result");

endmodule

/* design/one_shot_periodic_alarm_bank.sv */
// one_shot_periodic_alarm_bank: top level of the alarm slot bank
// joins ospab_ctrl and ospab_dp; uses ospab_pkg
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   ospab_pkg::in_item_t
//  rsp      out        rsp_valid/rsp_stall   ospab_pkg::out_item_t
//
// one item at a time: a register operation loads its result in the exec state, once the
// output register has room; a tick decodes in the exec state, then reads one
// slot per cycle from the alarm/period memory while no due slot waits for room in
// the output register, and loads its closing result in the close state
// any result waits while the one before it is stalled on rsp
// reset clears all slot flags; the memory needs no clearing since its entries
// are read only for allocated slots and create writes zeros
module one_shot_periodic_alarm_bank #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  ospab_pkg::in_item_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output ospab_pkg::out_item_t rsp
);

	ospab_pkg::cmd_t cmd;
	ospab_pkg::sts_t sts;

	ospab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ospab_dp #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

/* verif/ospab_checker.sv */
// ospab_checker: watches the req and rsp channels of the alarm bank, predicts every rsp item
// and compares it with the oldest prediction; reports a failure count and the backlog
// depends on ospab_pkg
module ospab_checker #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  ospab_pkg::in_item_t  req,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  ospab_pkg::out_item_t rsp,
	output int                   errors,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic        slot_used  [NUM_SLOTS];
	logic        slot_armed [NUM_SLOTS];
	logic [63:0] alarm_at   [NUM_SLOTS];
	logic [63:0] period_len [NUM_SLOTS];

	ospab_pkg::out_item_t rsp_expected_q[$];
	int                   fail_tally = 0;

	function automatic ospab_pkg::out_item_t rsp_item(logic [1:0] st, logic [3:0] sl,
			logic act, logic [63:0] tn, logic f, logic l);
		ospab_pkg::out_item_t r;
		r.status = st;
		r.result_slot = sl;
		r.is_active = act;
		r.time_now_us = tn;
		r.fired = f;
		r.last = l;
		return r;
	endfunction

	function automatic logic [1:0] try_arm(int s, logic [63:0] when, logic [63:0] per);
		if (when == 64'd0)
			return ospab_pkg::ST_INVAL;
		if (slot_armed[s])
			return ospab_pkg::ST_STATE;
		alarm_at[s] = when;
		period_len[s] = per;
		slot_armed[s] = 1'b1;
		return ospab_pkg::ST_OK;
	endfunction

	task automatic predict_rsp(input ospab_pkg::in_item_t it);
		int         s;
		logic       ok;
		logic [1:0] st;
		bit         single;
		s = int'(it.slot);
		ok = (s < NUM_SLOTS) && slot_used[s];
		st = ospab_pkg::ST_OK;
		single = 1'b1;
		case (it.operation)
			ospab_pkg::OP_CREATE: begin
				st = ospab_pkg::ST_NO_FREE;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (!slot_used[i] && st == ospab_pkg::ST_NO_FREE) begin
						slot_used[i] = 1'b1;
						slot_armed[i] = 1'b0;
						alarm_at[i] = '0;
						period_len[i] = '0;
						st = ospab_pkg::ST_OK;
						single = 1'b0;
						rsp_expected_q.push_back(rsp_item(ospab_pkg::ST_OK, 4'(i), 1'b0, '0,
							1'b0, 1'b1));
					end
				end
			end
			ospab_pkg::OP_DELETE: begin
				if (!ok) begin
					st = ospab_pkg::ST_INVAL;
				end else begin
					slot_used[s] = 1'b0;
					slot_armed[s] = 1'b0;
					alarm_at[s] = '0;
					period_len[s] = '0;
				end
			end
			ospab_pkg::OP_ONCE: begin
				if (!ok) st = ospab_pkg::ST_INVAL;
				else st = try_arm(s, it.now_us + it.time_us, '0);
			end
			ospab_pkg::OP_ONCE_AT: begin
				if (!ok || it.time_us <= it.now_us) st = ospab_pkg::ST_INVAL;
				else st = try_arm(s, it.time_us, '0);
			end
			ospab_pkg::OP_PERIODIC: begin
				if (!ok) st = ospab_pkg::ST_INVAL;
				else st = try_arm(s, it.now_us + it.time_us, it.time_us);
			end
			ospab_pkg::OP_PERIODIC_AT: begin
				if (!ok || it.first_at_us <= it.now_us) st = ospab_pkg::ST_INVAL;
				else st = try_arm(s, it.first_at_us, it.time_us);
			end
			ospab_pkg::OP_STOP: begin
				if (!ok) st = ospab_pkg::ST_INVAL;
				else if (!slot_armed[s]) st = ospab_pkg::ST_STATE;
				else slot_armed[s] = 1'b0;
			end
			ospab_pkg::OP_RESTART: begin
				if (!ok) begin
					st = ospab_pkg::ST_INVAL;
				end else if (!slot_armed[s] || it.time_us == 64'd0) begin
					st = ospab_pkg::ST_STATE;
				end else begin
					alarm_at[s] = it.now_us + it.time_us;
					if (period_len[s] != 64'd0)
						period_len[s] = it.time_us;
				end
			end
			ospab_pkg::OP_QUERY: begin
				single = 1'b0;
				rsp_expected_q.push_back(rsp_item(ospab_pkg::ST_OK, '0, ok && slot_armed[s],
					'0, 1'b0, 1'b1));
			end
			ospab_pkg::OP_TIME: begin
				single = 1'b0;
				rsp_expected_q.push_back(rsp_item(ospab_pkg::ST_OK, '0, 1'b0, it.now_us,
					1'b0, 1'b1));
			end
			ospab_pkg::OP_TICK: begin
				single = 1'b0;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (slot_used[i] && slot_armed[i] && alarm_at[i] <= it.now_us) begin
						// periodic slots move on by one period, one-shots drop out
						if (period_len[i] != 64'd0)
							alarm_at[i] = alarm_at[i] + period_len[i];
						else
							slot_armed[i] = 1'b0;
						rsp_expected_q.push_back(rsp_item(ospab_pkg::ST_OK, 4'(i), 1'b0, '0,
							1'b1, 1'b0));
					end
				end
				rsp_expected_q.push_back(rsp_item(ospab_pkg::ST_OK, '0, 1'b0, '0, 1'b0, 1'b1));
			end
			default: st = ospab_pkg::ST_INVAL;
		endcase
		if (single)
			rsp_expected_q.push_back(rsp_item(st, '0, 1'b0, '0, 1'b0, 1'b1));
	endtask

	function automatic bit field_differs(string name, logic [63:0] want, logic [63:0] got);
		if (want === got)
			return 1'b0;
		$display("%0t: rsp field %s expected %0h got %0h", $time, name, want, got);
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ospab_pkg::out_item_t want;
		bit                   bad;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_used[i] = 1'b0;
				slot_armed[i] = 1'b0;
				alarm_at[i] = '0;
				period_len[i] = '0;
			end
			rsp_expected_q.delete();
			outstanding <= 0;
		end else begin
			if (req_valid && !req_stall)
				predict_rsp(req);
			if (rsp_valid && !rsp_stall) begin
				if (rsp_expected_q.size() == 0) begin
					$display("%0t: rsp item with nothing expected, expected none got %h",
						$time, rsp);
					fail_tally++;
				end else begin
					want = rsp_expected_q.pop_front();
					bad = field_differs("status", 64'(want.status), 64'(rsp.status))
						| field_differs("result_slot", 64'(want.result_slot),
							64'(rsp.result_slot))
						| field_differs("is_active", 64'(want.is_active), 64'(rsp.is_active))
						| field_differs("time_now_us", want.time_now_us, rsp.time_now_us)
						| field_differs("fired", 64'(want.fired), 64'(rsp.fired))
						| field_differs("last", 64'(want.last), 64'(rsp.last));
					if (bad)
						fail_tally++;
				end
			end
			outstanding <= rsp_expected_q.size();
			errors <= fail_tally;
		end
	end

endmodule

/* verif/one_shot_periodic_alarm_bank_tb.sv */
// one_shot_periodic_alarm_bank_tb: drives req items into the alarm bank and stalls rsp,
// directed cases first and then random operation mixes; ospab_checker gives the verdict input
// depends on ospab_pkg, ospab_checker and one_shot_periodic_alarm_bank
module one_shot_periodic_alarm_bank_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SLOTS = 16;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 rsp_stall = 1'b0;
	ospab_pkg::in_item_t  req = '0;
	logic                 req_stall;
	logic                 rsp_valid;
	ospab_pkg::out_item_t rsp;
	int                   errors;
	int                   outstanding;

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	logic        hold_tgl = 1'b0;
	logic [63:0] now_us = '0;

	one_shot_periodic_alarm_bank #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	ospab_checker #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("one_shot_periodic_alarm_bank: mismatch");
		$finish;
	end

	// rsp side: random stalls, or one long hold-off each time hold_tgl flips
	initial begin : rsp_side
		logic seen_tgl;
		seen_tgl = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_tgl != seen_tgl) begin
				seen_tgl = hold_tgl;
				rsp_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	function automatic ospab_pkg::in_item_t mk(logic [3:0] op, logic [3:0] sl,
			logic [63:0] t, logic [63:0] first, logic [63:0] now);
		ospab_pkg::in_item_t it;
		it.operation = op;
		it.slot = sl;
		it.time_us = t;
		it.first_at_us = first;
		it.now_us = now;
		return it;
	endfunction

	task automatic offer(input ospab_pkg::in_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_span();
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1, 2: return {$urandom, $urandom};
			default: return 64'($urandom_range(1, 60));
		endcase
	endfunction

	task automatic run_random(input int count);
		ospab_pkg::in_item_t it;
		int                  r;
		logic [3:0]          sl;
		logic [63:0]         rnd;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 999);
			// well-formed bursts: fill the whole bank, or free every slot
			if (r < 15) begin
				for (int k = 0; k <= NUM_SLOTS; k++)
					offer(mk(ospab_pkg::OP_CREATE, 4'($urandom), {$urandom, $urandom}, '0,
						now_us));
				continue;
			end
			if (r < 25) begin
				for (int k = 0; k < NUM_SLOTS; k++)
					offer(mk(ospab_pkg::OP_DELETE, 4'(k), '0, {$urandom, $urandom}, now_us));
				continue;
			end
			r = $urandom_range(0, 99);
			if (r < 2) now_us = {$urandom, $urandom};
			else if (r < 3) now_us = 64'hFFFF_FFFF_FFFF_FF00 + 64'($urandom_range(0, 200));
			else now_us = now_us + 64'($urandom_range(0, 15));
			// mostly the low slots, where create puts the allocations
			sl = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, 5)) : 4'($urandom);
			rnd = {$urandom, $urandom};
			r = $urandom_range(0, 99);
			if (r < 5)
				it = mk(4'($urandom), 4'($urandom), {$urandom, $urandom}, rnd,
					{$urandom, $urandom});
			else if (r < 15)
				it = mk(ospab_pkg::OP_CREATE, sl, rnd, '0, now_us);
			else if (r < 20)
				it = mk(ospab_pkg::OP_DELETE, sl, rnd, '0, now_us);
			else if (r < 30)
				it = mk(ospab_pkg::OP_ONCE, sl, pick_span(), rnd, now_us);
			else if (r < 37)
				it = mk(ospab_pkg::OP_ONCE_AT, sl, ($urandom_range(0, 9) == 0) ? rnd
					: now_us + 64'($urandom_range(0, 60)) - 64'd5, '0, now_us);
			else if (r < 47)
				it = mk(ospab_pkg::OP_PERIODIC, sl, pick_span(), rnd, now_us);
			else if (r < 54)
				it = mk(ospab_pkg::OP_PERIODIC_AT, sl, ($urandom_range(0, 4) == 0) ? pick_span()
					: 64'($urandom_range(0, 30)), ($urandom_range(0, 9) == 0) ? rnd
					: now_us + 64'($urandom_range(0, 60)) - 64'd3, now_us);
			else if (r < 60)
				it = mk(ospab_pkg::OP_STOP, sl, rnd, '0, now_us);
			else if (r < 66)
				it = mk(ospab_pkg::OP_RESTART, sl, pick_span(), rnd, now_us);
			else if (r < 70)
				it = mk(ospab_pkg::OP_QUERY, sl, rnd, '0, now_us);
			else if (r < 73)
				it = mk(ospab_pkg::OP_TIME, sl, '0, rnd, now_us);
			else
				it = mk(ospab_pkg::OP_TICK, sl, '0, '0, now_us);
			offer(it);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: error codes, both start styles, wrap of the alarm sum
		offer(mk(ospab_pkg::OP_QUERY, 4'd0, '0, '0, 64'd0));
		offer(mk(ospab_pkg::OP_DELETE, 4'd15, '0, '0, 64'd0));
		offer(mk(ospab_pkg::OP_TIME, 4'd0, '0, '0, '1));
		offer(mk(ospab_pkg::OP_TICK, 4'd0, '0, '0, 64'd0));
		repeat (4) offer(mk(ospab_pkg::OP_CREATE, 4'd0, '0, '0, 64'd0));
		offer(mk(ospab_pkg::OP_ONCE, 4'd0, 64'd0, '0, 64'd0));
		offer(mk(ospab_pkg::OP_ONCE, 4'd0, 64'd5, '0, 64'd100));
		offer(mk(ospab_pkg::OP_ONCE, 4'd0, 64'd9, '0, 64'd100));
		offer(mk(ospab_pkg::OP_ONCE_AT, 4'd1, 64'd100, '0, 64'd100));
		offer(mk(ospab_pkg::OP_ONCE_AT, 4'd1, 64'd200, '0, 64'd100));
		offer(mk(ospab_pkg::OP_PERIODIC, 4'd2, 64'd0, '0, 64'd100));
		offer(mk(ospab_pkg::OP_PERIODIC_AT, 4'd3, 64'd10, 64'd100, 64'd100));
		offer(mk(ospab_pkg::OP_PERIODIC_AT, 4'd3, 64'd10, 64'd150, 64'd100));
		offer(mk(ospab_pkg::OP_RESTART, 4'd2, 64'd0, '0, 64'd100));
		offer(mk(ospab_pkg::OP_RESTART, 4'd3, 64'd25, '0, 64'd100));
		offer(mk(ospab_pkg::OP_TICK, 4'd0, '0, '0, 64'd200));
		offer(mk(ospab_pkg::OP_STOP, 4'd0, '0, '0, 64'd200));
		offer(mk(ospab_pkg::OP_STOP, 4'd3, '0, '0, 64'd200));
		offer(mk(ospab_pkg::OP_ONCE_AT, 4'd1, '1, '0, 64'd200));
		offer(mk(ospab_pkg::OP_ONCE, 4'd2, 64'h20, '0, 64'hFFFF_FFFF_FFFF_FFF0));
		offer(mk(ospab_pkg::OP_QUERY, 4'd2, '0, '0, 64'd0));
		offer(mk(4'd15, 4'd0, '0, '0, 64'd0));
		offer(mk(ospab_pkg::OP_TICK, 4'd0, '0, '0, 64'h10));
		req_valid <= 1'b0;
		wait_drained();

		send_idle_pct = 10;
		recv_idle_pct = 81;
		run_random(60);
		hold_tgl <= ~hold_tgl;
		run_random(60);
		req_valid <= 1'b0;
		wait_drained();

		send_idle_pct = 81;
		recv_idle_pct = 10;
		run_random(110);
		req_valid <= 1'b0;
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(110);
		req_valid <= 1'b0;
		wait_drained();
		repeat (3 * NUM_SLOTS) @(posedge clk);

		if (errors == 0 && outstanding == 0)
			$display("one_shot_periodic_alarm_bank: match");
		else
			$display("one_shot_periodic_alarm_bank: mismatch");
		$finish;
	end

endmodule

/* one_shot_periodic_alarm_bank.f */
design/ospab_pkg.sv
design/ospab_ctrl.sv
design/ospab_dp.sv
design/one_shot_periodic_alarm_bank.sv
verif/ospab_checker.sv
verif/one_shot_periodic_alarm_bank_tb.sv
